/* src/cbim_pkg.sv */
// cbim_pkg: shared types and constants for the cartridge bank irq mapper
// no dependencies; imported by cbim_irq_counter, cartridge_bank_irq_mapper, cbim_checker and the testbench

package cbim_pkg;

  // stream payload widths
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 112;

  // request kind carried in tuser
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // address page codes (address bits 15..12)
  localparam logic [3:0] PAGE_PRG_LO    = 4'h8;
  localparam logic [3:0] PAGE_PRG_HI    = 4'h9;
  localparam logic [3:0] PAGE_CHR_FIRST = 4'hA;
  localparam logic [3:0] PAGE_CHR_LAST  = 4'hD;
  localparam logic [3:0] PAGE_LATCH     = 4'hE;
  localparam logic [3:0] PAGE_CTRL      = 4'hF;

  // control page offsets (address bits 11..0)
  localparam logic [11:0] CTRL_RELOAD = 12'h000;
  localparam logic [11:0] CTRL_MODE   = 12'h001;
  localparam logic [11:0] CTRL_MIRROR = 12'h002;

  // counter width masks
  localparam logic [15:0] MASK_4  = 16'h000F;
  localparam logic [15:0] MASK_8  = 16'h00FF;
  localparam logic [15:0] MASK_12 = 16'h0FFF;
  localparam logic [15:0] MASK_16 = 16'hFFFF;

  // irq control byte bit positions
  localparam int unsigned MODE_EN_BIT  = 0;
  localparam int unsigned MODE_12_BIT  = 1;
  localparam int unsigned MODE_8_BIT   = 2;
  localparam int unsigned MODE_4_BIT   = 3;

  // command from the bus decoder to the irq counter
  typedef struct packed {
    logic       tick;
    logic       reload;
    logic       mode_wr;
    logic       latch_wr;
    logic [1:0] latch_sel;
    logic [7:0] data;
  } irq_cmd_t;

endpackage

/* src/cbim_irq_counter.sv */
// cbim_irq_counter: reload latch, irq control bits, down-counter and irq flag
// depends on cbim_pkg (irq_cmd_t, masks, mode bit positions)

module cbim_irq_counter import cbim_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  irq_cmd_t    cmd_i,
  output logic [15:0] count_o,
  output logic        irq_o
);

  logic [15:0] latch_q, latch_d;
  logic [15:0] count_q, count_d;
  logic [3:0]  mode_q, mode_d;
  logic        irq_q, irq_d;

  logic [15:0] mask;
  logic [15:0] low_bits;

  // width select and masked decrement
  always_comb begin
    if (mode_q[MODE_4_BIT]) begin
      mask = MASK_4;
    end else if (mode_q[MODE_8_BIT]) begin
      mask = MASK_8;
    end else if (mode_q[MODE_12_BIT]) begin
      mask = MASK_12;
    end else begin
      mask = MASK_16;
    end
    low_bits = ((count_q & mask) - 16'd1) & mask;
  end

  // next state for one command
  always_comb begin
    latch_d = latch_q;
    count_d = count_q;
    mode_d  = mode_q;
    irq_d   = irq_q;
    if (cmd_i.tick) begin
      count_d = (count_q & ~mask) | low_bits;
      if ((low_bits == 16'd0) && mode_q[MODE_EN_BIT]) begin
        irq_d = 1'b1;
      end
    end
    if (cmd_i.latch_wr) begin
      for (int i = 0; i < 4; i++) begin
        if (cmd_i.latch_sel == 2'(i)) begin
          latch_d[4*i +: 4] = cmd_i.data[3:0];
        end
      end
    end
    if (cmd_i.reload) begin
      count_d = latch_q;
      irq_d   = 1'b0;
    end
    if (cmd_i.mode_wr) begin
      mode_d = cmd_i.data[3:0];
      irq_d  = 1'b0;
    end
  end

  // state registers, updated once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q <= '0;
      count_q <= '0;
      mode_q  <= '0;
      irq_q   <= 1'b0;
    end else if (en_i) begin
      latch_q <= latch_d;
      count_q <= count_d;
      mode_q  <= mode_d;
      irq_q   <= irq_d;
    end
  end

  assign count_o = count_q;
  assign irq_o   = irq_q;

endmodule

/* src/cartridge_bank_irq_mapper.sv */
// Cartridge bank mapper with irq down-counter. Each input transfer is either a
// CPU bus write (tuser low) or one CPU cycle tick (tuser high); every transfer
// yields exactly one output transfer carrying the full mapping state after that
// item. One item per clock is sustained while the output side accepts; each item
// passes the input register and then the state update, whose registers are the result.
// depends on cbim_pkg and cbim_irq_counter

module cartridge_bank_irq_mapper import cbim_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // slave side
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // address[15:0], value[23:16]
  input  logic                s_axis_tuser_i,   // req_type
  // master side
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // prg_bank_8000[7:0], prg_bank_a000[15:8], prg_bank_c000[23:16],
  // chr_banks[87:24], mirroring[89:88], irq_pending[90], irq_count[106:91],
  // zero fill[111:107]
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  // input register
  logic        s1_valid_q, s1_valid_d;
  logic        s1_kind_q;
  logic [15:0] s1_addr_q;
  logic [7:0]  s1_value_q;
  logic        out_valid_q, out_valid_d;

  logic        in_fire;
  logic        out_free;
  logic        s1_fire;

  // bank state, doubles as the result register
  logic [3:0]  prg_nib_q [6];
  logic [3:0]  chr_nib_q [16];
  logic [1:0]  mirror_q;

  logic        bus_wr;
  logic [3:0]  page;
  logic [3:0]  chr_page_ofs;
  logic        prg_we;
  logic [2:0]  prg_idx;
  logic        chr_we;
  logic [3:0]  chr_idx;
  logic        mirror_we;
  irq_cmd_t    irq_cmd;
  logic [15:0] irq_count;
  logic        irq_pending;

  // handshake: stage moves whenever the result slot is free or being taken
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s1_fire         = s1_valid_q && out_free;
  assign s_axis_tready_o = !s1_valid_q || out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // capture the input transfer
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q  <= s_axis_tuser_i;
      s1_addr_q  <= s_axis_tdata_i[15:0];
      s1_value_q <= s_axis_tdata_i[23:16];
    end
  end

  // address decode
  always_comb begin
    page         = s1_addr_q[15:12];
    bus_wr       = (s1_kind_q == REQ_WRITE) && s1_addr_q[15];
    chr_page_ofs = page - PAGE_CHR_FIRST;

    prg_we  = 1'b0;
    prg_idx = {1'b0, s1_addr_q[1:0]};
    if (page == PAGE_PRG_LO && s1_addr_q[3:2] == 2'b00) begin
      prg_we = bus_wr;
    end else if (page == PAGE_PRG_HI && s1_addr_q[3:1] == 3'b000) begin
      prg_we  = bus_wr;
      prg_idx = 3'd4 + {2'b00, s1_addr_q[0]};
    end

    chr_we  = bus_wr && (page >= PAGE_CHR_FIRST) && (page <= PAGE_CHR_LAST);
    chr_idx = {chr_page_ofs[1:0], s1_addr_q[1:0]};

    mirror_we = bus_wr && (page == PAGE_CTRL) && (s1_addr_q[11:0] == CTRL_MIRROR);

    irq_cmd.tick      = (s1_kind_q == REQ_TICK);
    irq_cmd.reload    = bus_wr && (page == PAGE_CTRL) && (s1_addr_q[11:0] == CTRL_RELOAD);
    irq_cmd.mode_wr   = bus_wr && (page == PAGE_CTRL) && (s1_addr_q[11:0] == CTRL_MODE);
    irq_cmd.latch_wr  = bus_wr && (page == PAGE_LATCH) && (s1_addr_q[3:2] == 2'b00);
    irq_cmd.latch_sel = s1_addr_q[1:0];
    irq_cmd.data      = s1_value_q;
  end

  // bank nibble and mirroring registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        prg_nib_q[i] <= '0;
      end
      for (int i = 0; i < 16; i++) begin
        chr_nib_q[i] <= '0;
      end
      mirror_q <= '0;
    end else if (s1_fire) begin
      for (int i = 0; i < 6; i++) begin
        if (prg_we && prg_idx == 3'(i)) begin
          prg_nib_q[i] <= s1_value_q[3:0];
        end
      end
      for (int i = 0; i < 16; i++) begin
        if (chr_we && chr_idx == 4'(i)) begin
          chr_nib_q[i] <= s1_value_q[3:0];
        end
      end
      if (mirror_we) begin
        mirror_q <= s1_value_q[1:0];
      end
    end
  end

  // irq counter
  cbim_irq_counter u_irq_counter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (s1_fire),
    .cmd_i   (irq_cmd),
    .count_o (irq_count),
    .irq_o   (irq_pending)
  );

  // result packing
  always_comb begin
    m_axis_tdata_o = '0;
    for (int i = 0; i < 3; i++) begin
      m_axis_tdata_o[8*i +: 8] = {prg_nib_q[2*i+1], prg_nib_q[2*i]};
    end
    for (int i = 0; i < 8; i++) begin
      m_axis_tdata_o[24 + 8*i +: 8] = {chr_nib_q[2*i+1], chr_nib_q[2*i]};
    end
    m_axis_tdata_o[89:88]  = mirror_q;
    m_axis_tdata_o[90]     = irq_pending;
    m_axis_tdata_o[106:91] = irq_count;
  end

`ifndef SYNTHESIS
  // a held item in the input stage is never dropped
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_fire |=> s1_valid_q)
    else $error("input stage item lost while stalled");

  // every item leaving the input stage produces a result
  a_s1_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("item consumed without a result");

  // mapping state only changes when a new result is loaded
  a_state_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(m_axis_tdata_o))
    else $error("result changed without an item");

  // counter reload acknowledges the irq
  a_reload_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && irq_cmd.reload |=> !irq_pending)
    else $error("irq still pending after reload");
`endif

endmodule

/* test/cbim_checker.sv */
// cbim_checker: watches both stream channels of the cartridge bank irq mapper,
// predicts the mapping state after each input transfer and compares results
// depends on cbim_pkg for the page, offset, mask and mode bit constants
`timescale 1ns / 1ps

module cbim_checker import cbim_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,   // address[15:0], value[23:16]
  input  logic                s_tuser_i,   // req_type
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,   // see the block's port list
  output int                  fail_count_o,
  output int                  pending_o
);

  // one result, last declared field in the lowest bits
  typedef struct packed {
    logic [15:0] irq_count;
    logic        irq_pending;
    logic [1:0]  mirroring;
    logic [63:0] chr_banks;
    logic [7:0]  prg_bank_c000;
    logic [7:0]  prg_bank_a000;
    logic [7:0]  prg_bank_8000;
  } map_state_t;

  // shadow copy of the mapper state
  logic [3:0]  prg_nib [6];
  logic [3:0]  chr_nib [16];
  logic [15:0] latch_val;
  logic [15:0] counter_val;
  logic [7:0]  irq_ctrl;
  logic [1:0]  mirror_val;
  logic        irq_level;

  map_state_t mapping_q [$];

  // decrement the selected low counter bits, raise the irq at zero
  function automatic void count_tick();
    logic [15:0] mask;
    logic [15:0] low_bits;
    if (irq_ctrl[MODE_4_BIT])       mask = MASK_4;
    else if (irq_ctrl[MODE_8_BIT])  mask = MASK_8;
    else if (irq_ctrl[MODE_12_BIT]) mask = MASK_12;
    else                            mask = MASK_16;
    low_bits = (counter_val - 16'd1) & mask;
    counter_val = (counter_val & ~mask) | low_bits;
    if (low_bits == 16'd0 && irq_ctrl[MODE_EN_BIT]) irq_level = 1'b1;
  endfunction

  // decode one cpu write into the shadow registers
  function automatic void bus_store(logic [15:0] addr, logic [7:0] val);
    logic [3:0] page;
    logic [3:0] page_idx;
    page = addr[15:12];
    if (page == PAGE_PRG_LO) begin
      if (addr[3:0] <= 4'd3) prg_nib[addr[1:0]] = val[3:0];
    end else if (page == PAGE_PRG_HI) begin
      if (addr[3:0] <= 4'd1) prg_nib[4 + addr[0]] = val[3:0];
    end else if (page >= PAGE_CHR_FIRST && page <= PAGE_CHR_LAST) begin
      page_idx = page - PAGE_CHR_FIRST;
      chr_nib[{page_idx[1:0], addr[1:0]}] = val[3:0];
    end else if (page == PAGE_LATCH) begin
      if (addr[3:0] <= 4'd3) latch_val[{addr[1:0], 2'b00} +: 4] = val[3:0];
    end else if (page == PAGE_CTRL) begin
      if (addr[11:0] == CTRL_RELOAD) begin
        counter_val = latch_val;
        irq_level = 1'b0;
      end else if (addr[11:0] == CTRL_MODE) begin
        irq_ctrl = val;
        irq_level = 1'b0;
      end else if (addr[11:0] == CTRL_MIRROR) begin
        mirror_val = val[1:0];
      end
    end
  endfunction

  // apply one request and return the state that the block should report
  function automatic map_state_t next_mapping(logic kind, logic [15:0] addr,
                                              logic [7:0] val);
    map_state_t res;
    if (kind == REQ_TICK) count_tick();
    else if (addr[15]) bus_store(addr, val);
    res.prg_bank_8000 = {prg_nib[1], prg_nib[0]};
    res.prg_bank_a000 = {prg_nib[3], prg_nib[2]};
    res.prg_bank_c000 = {prg_nib[5], prg_nib[4]};
    for (int i = 0; i < 8; i++) res.chr_banks[8*i +: 8] = {chr_nib[2*i+1], chr_nib[2*i]};
    res.mirroring   = mirror_val;
    res.irq_pending = irq_level;
    res.irq_count   = counter_val;
    return res;
  endfunction

  task automatic compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      fail_count_o++;
    end
  endtask

  // predict on input transfers, check on output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    map_state_t exp_map;
    map_state_t act_map;
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) prg_nib[i] = 4'd0;
      for (int i = 0; i < 16; i++) chr_nib[i] = 4'd0;
      latch_val    = 16'd0;
      counter_val  = 16'd0;
      irq_ctrl     = 8'd0;
      mirror_val   = 2'd0;
      irq_level    = 1'b0;
      fail_count_o = 0;
      mapping_q.delete();
    end else begin
      if (s_tvalid_i && s_tready_i)
        mapping_q.push_back(next_mapping(s_tuser_i, s_tdata_i[15:0], s_tdata_i[23:16]));
      if (m_tvalid_i && m_tready_i) begin
        act_map = m_tdata_i[$bits(map_state_t)-1:0];
        if (mapping_q.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, actual %h",
                   $time, act_map);
          fail_count_o++;
        end else begin
          exp_map = mapping_q.pop_front();
          compare_field("prg_bank_8000", 64'(exp_map.prg_bank_8000),
                        64'(act_map.prg_bank_8000));
          compare_field("prg_bank_a000", 64'(exp_map.prg_bank_a000),
                        64'(act_map.prg_bank_a000));
          compare_field("prg_bank_c000", 64'(exp_map.prg_bank_c000),
                        64'(act_map.prg_bank_c000));
          compare_field("chr_banks", exp_map.chr_banks, act_map.chr_banks);
          compare_field("mirroring", 64'(exp_map.mirroring), 64'(act_map.mirroring));
          compare_field("irq_pending", 64'(exp_map.irq_pending),
                        64'(act_map.irq_pending));
          compare_field("irq_count", 64'(exp_map.irq_count), 64'(act_map.irq_count));
        end
      end
    end
    pending_o = mapping_q.size();
  end

endmodule

/* test/tb_cartridge_bank_irq_mapper.sv */
// tb_cartridge_bank_irq_mapper: drives cpu writes and ticks into the mapper
// with random gaps and stalls; cbim_checker does prediction and comparison
// depends on cbim_pkg, cbim_checker and cartridge_bank_irq_mapper
`timescale 1ns / 1ps

module tb_cartridge_bank_irq_mapper;
  import cbim_pkg::*;

  localparam int NumItems    = 1450;
  localparam int HoldCycles  = 150;
  localparam int CycleLimit  = 100000;
  localparam int DrainCycles = 10;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                s_tuser = REQ_WRITE;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  int                  fail_count;
  int                  pending;
  int                  cycle_count = 0;
  int                  n_sent = 0;
  bit                  snd_steady = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  cartridge_bank_irq_mapper dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  cbim_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // offer one request and hold it until the transfer
  task automatic send_req(logic kind, logic [15:0] addr, logic [7:0] val);
    int gap;
    gap = snd_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {val, addr};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic cpu_write(logic [15:0] addr, logic [7:0] val);
    send_req(REQ_WRITE, addr, val);
  endtask

  task automatic cpu_tick();
    send_req(REQ_TICK, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
  endtask

  // load the latch, reload, program the mode, then let the counter run
  task automatic irq_sequence();
    logic [7:0] mode_byte;
    int         n_ticks;
    for (int i = 0; i < 4; i++) begin
      if (i == 0 || $urandom_range(0, 2) == 0)
        cpu_write({PAGE_LATCH, 8'($urandom_range(0, 255)), 4'(i)},
                  8'($urandom_range(0, 255)));
      else
        cpu_write({PAGE_LATCH, 8'($urandom_range(0, 255)), 4'(i)},
                  {4'($urandom_range(0, 15)), 4'h0});
    end
    cpu_write({PAGE_CTRL, CTRL_RELOAD}, 8'($urandom_range(0, 255)));
    mode_byte = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) != 0) mode_byte[MODE_EN_BIT] = 1'b1;
    cpu_write({PAGE_CTRL, CTRL_MODE}, mode_byte);
    n_ticks = $urandom_range(1, 40);
    for (int i = 0; i < n_ticks; i++) begin
      // occasional acknowledge while counting
      if ($urandom_range(0, 9) == 0)
        cpu_write({PAGE_CTRL, ($urandom_range(0, 1) == 0) ? CTRL_RELOAD : CTRL_MODE},
                  8'($urandom_range(0, 255)));
      else
        cpu_tick();
    end
  endtask

  // random bank register writes, mostly to decoded offsets
  task automatic bank_writes();
    int         n_wr;
    logic [3:0] page;
    n_wr = $urandom_range(1, 8);
    for (int i = 0; i < n_wr; i++) begin
      page = 4'($urandom_range(PAGE_PRG_LO, PAGE_CHR_LAST));
      if ($urandom_range(0, 3) == 0)
        cpu_write({page, 12'($urandom_range(0, 4095))}, 8'($urandom_range(0, 255)));
      else
        cpu_write({page, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 3))},
                  8'($urandom_range(0, 255)));
    end
  endtask

  // receiver: random stalls, steady stretches and long hold-offs
  initial begin : receiver
    int n_results;
    int stall;
    bit rcv_steady;
    n_results = 0;
    rcv_steady = 0;
    @(posedge rst_ni);
    forever begin
      if (n_results % 40 == 0) rcv_steady = ($urandom_range(0, 3) == 0);
      if (n_results == 400 || n_results == 1000) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        stall = rcv_steady ? 0 : $urandom_range(0, 3);
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid) @(posedge clk_i);
      n_results++;
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int pick;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // writes below the mapped range are ignored
    cpu_write(16'h0000, 8'hFF);
    cpu_write(16'h7FFF, 8'hAB);
    // program banks, including ignored offsets
    cpu_write(16'h8000, 8'hF1);
    cpu_write(16'h8001, 8'h02);
    cpu_write(16'h8FF3, 8'hFF);
    cpu_write(16'h8004, 8'h77);
    cpu_write(16'h9000, 8'h15);
    cpu_write(16'h9001, 8'hFF);
    cpu_write(16'h900F, 8'h33);
    // pattern banks at the page extremes
    cpu_write(16'hA000, 8'h0A);
    cpu_write(16'hBFFF, 8'hFB);
    cpu_write(16'hC002, 8'h0C);
    cpu_write(16'hDFFD, 8'hFF);
    // latch = 0x0005, ignored latch offset
    cpu_write(16'hE000, 8'hF5);
    cpu_write(16'hE001, 8'h00);
    cpu_write(16'hE002, 8'h00);
    cpu_write(16'hE003, 8'hF0);
    cpu_write(16'hE004, 8'hFF);
    // mirroring, 4-bit mode with enable, reload, ignored control offsets
    cpu_write({PAGE_CTRL, CTRL_MIRROR}, 8'hFF);
    cpu_write({PAGE_CTRL, CTRL_MODE}, 8'h09);
    cpu_write({PAGE_CTRL, CTRL_RELOAD}, 8'h00);
    cpu_write(16'hFFFF, 8'hFF);
    cpu_write(16'hF003, 8'h00);
    // count down through zero and wrap inside the 4-bit field
    repeat (6) send_req(REQ_TICK, 16'hFFFF, 8'hFF);
    // 16-bit mode without enable decrements the whole counter
    cpu_write({PAGE_CTRL, CTRL_MODE}, 8'h00);
    repeat (2) send_req(REQ_TICK, 16'h0000, 8'h00);

    // random part
    while (n_sent < NumItems) begin
      snd_steady = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        irq_sequence();
      end else if (pick <= 6) begin
        bank_writes();
      end else if (pick == 7) begin
        cpu_write({PAGE_CTRL, CTRL_MIRROR}, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6))
          send_req(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                   8'($urandom_range(0, 255)));
      end
    end
    s_tvalid <= 1'b0;

    // drain
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
